FILE: rtl/tcp_pkg.sv
// ---------------------------------------------------------------------------
// tcp_pkg
// Shared types and constants for the thresholded colocalization pass.
// ---------------------------------------------------------------------------
package tcp_pkg;

	localparam int SampleBitsDef = 8;
	localparam int VoxelCountBitsDef = 24;
	localparam int NumStats = 19;
	localparam int StatBits = 40;
	localparam int IdxBits = 5;
	localparam int CfgIdxBits = 3;
	localparam int MapBits = 8;

	localparam logic [CfgIdxBits-1:0] RegCh1Lower = 3'd0;
	localparam logic [CfgIdxBits-1:0] RegCh2Lower = 3'd1;
	localparam logic [CfgIdxBits-1:0] RegCh1Upper = 3'd2;
	localparam logic [CfgIdxBits-1:0] RegCh2Upper = 3'd3;
	localparam logic [CfgIdxBits-1:0] RegFixedMap = 3'd4;

	localparam logic [0:0] KindMap = 1'b0;
	localparam logic [0:0] KindStat = 1'b1;

	// Counts saturate at the voxel-count limit, sums at the full width.
	localparam logic [NumStats-1:0] IsCountStat = 19'b000_0010_0001_1001_1100;

	typedef struct packed {
		logic [SampleBitsDef-1:0] ch1_sample;
		logic [SampleBitsDef-1:0] ch2_sample;
		logic                     last_voxel;
	} in_item_t;

	typedef struct packed {
		logic                kind;
		logic [MapBits-1:0]  map_value;
		logic                is_coloc;
		logic [IdxBits-1:0]  stat_index;
		logic [StatBits-1:0] stat_value;
		logic                end_of_run;
	} out_item_t;

	typedef struct packed {
		logic [MapBits-1:0] ch1_lower;
		logic [MapBits-1:0] ch2_lower;
		logic [MapBits-1:0] ch1_upper;
		logic [MapBits-1:0] ch2_upper;
		logic [MapBits-1:0] fixed_map_value;
	} cfg_t;

	// Classified voxel handed from front to back.
	typedef struct packed {
		logic [SampleBitsDef-1:0] a;
		logic [SampleBitsDef-1:0] b;
		logic                     in1;
		logic                     in2;
		logic                     last;
		logic [MapBits-1:0]       map;
	} voxel_t;

endpackage

FILE: rtl/tcp_front.sv
// ---------------------------------------------------------------------------
// tcp_front
// Accepts voxels, tests thresholds, forms the map (fixed or bit-serial sqrt).
// ---------------------------------------------------------------------------
module tcp_front #(
	parameter int SampleBits = tcp_pkg::SampleBitsDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [SampleBits-1:0] in_a,
	input  logic [SampleBits-1:0] in_b,
	input  logic                in_last,
	input  tcp_pkg::cfg_t       cfg,
	output logic                v_valid,
	input  logic                v_ready,
	output tcp_pkg::voxel_t     v_data
);
	localparam int ProdBits = 2 * SampleBits;
	localparam int RootBits = SampleBits;
	localparam int StepBits = $clog2(RootBits + 1);

	logic                  busy_q;
	logic                  done_q;
	logic [StepBits-1:0]   step_q;
	logic [ProdBits-1:0]   rem_q;
	logic [RootBits-1:0]   root_q;
	logic [SampleBits-1:0] a_q, b_q;
	logic                  in1_q, in2_q, last_q;
	logic [tcp_pkg::MapBits-1:0] map_q;

	logic in1, in2;
	logic [ProdBits-1:0] prod;
	logic [ProdBits+1:0] trial;
	logic [ProdBits+1:0] shifted;
	logic [RootBits-1:0] root_n;
	logic                fits;

	assign in_stall = busy_q || done_q;
	assign in1 = ({8'd0, in_a} >= {{SampleBits{1'b0}}, cfg.ch1_lower})
		&& ({8'd0, in_a} <= {{SampleBits{1'b0}}, cfg.ch1_upper});
	assign in2 = ({8'd0, in_b} >= {{SampleBits{1'b0}}, cfg.ch2_lower})
		&& ({8'd0, in_b} <= {{SampleBits{1'b0}}, cfg.ch2_upper});
	assign prod = ProdBits'(in_a) * ProdBits'(in_b);

	// One root bit per cycle, restoring method on the remainder.
	always_comb begin
		shifted = {2'b00, rem_q};
		trial = ({2'b00, {(ProdBits-RootBits){1'b0}}, root_q} << (step_q + 1'b1))
			| ((ProdBits+2)'(1) << (2 * step_q));
		fits = shifted >= trial;
		root_n = root_q | (fits ? (RootBits'(1) << step_q) : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				a_q <= in_a;
				b_q <= in_b;
				in1_q <= in1;
				in2_q <= in2;
				last_q <= in_last;
				rem_q <= prod;
				root_q <= '0;
				step_q <= StepBits'(RootBits - 1);
				if (in1 && in2 && cfg.fixed_map_value == '0) begin
					busy_q <= 1'b1;
				end else begin
					done_q <= 1'b1;
					map_q <= (in1 && in2) ? cfg.fixed_map_value : '0;
				end
			end else if (busy_q) begin
				root_q <= root_n;
				if (fits) begin
					rem_q <= ProdBits'(shifted - trial);
				end
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					map_q <= root_n[tcp_pkg::MapBits-1:0];
				end else begin
					step_q <= step_q - 1'b1;
				end
			end else if (done_q && v_ready) begin
				done_q <= 1'b0;
			end
		end
	end

	assign v_valid = done_q;
	always_comb begin
		v_data.a = a_q;
		v_data.b = b_q;
		v_data.in1 = in1_q;
		v_data.in2 = in2_q;
		v_data.last = last_q;
		v_data.map = map_q;
	end
endmodule

FILE: rtl/tcp_queue.sv
// ---------------------------------------------------------------------------
// tcp_queue
// Two-entry queue between the classifier and the accumulator/drain side.
// ---------------------------------------------------------------------------
module tcp_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_valid,
	output logic            wr_ready,
	input  tcp_pkg::voxel_t wr_data,
	output logic            rd_valid,
	input  logic            rd_ready,
	output tcp_pkg::voxel_t rd_data
);
	tcp_pkg::voxel_t mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       wr, rd;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end
endmodule

FILE: rtl/tcp_back.sv
// ---------------------------------------------------------------------------
// tcp_back
// Updates the nineteen accumulators, emits map results and drains statistics.
// ---------------------------------------------------------------------------
module tcp_back #(
	parameter int SampleBits = tcp_pkg::SampleBitsDef,
	parameter int VoxelCountBits = tcp_pkg::VoxelCountBitsDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               v_valid,
	output logic               v_ready,
	input  tcp_pkg::voxel_t    v_data,
	output logic               out_valid,
	input  logic               out_stall,
	output tcp_pkg::out_item_t out_data
);
	localparam int N = tcp_pkg::NumStats;
	localparam int W = tcp_pkg::StatBits;
	localparam int IB = tcp_pkg::IdxBits;
	localparam logic [W-1:0] SumMax = '1;
	localparam logic [W-1:0] CountMax = W'((41'd1 << VoxelCountBits) - 41'd1);
	localparam int PB = 2 * SampleBits;

	localparam logic [1:0] StIdle = 2'd0;
	localparam logic [1:0] StMap = 2'd1;
	localparam logic [1:0] StDrain = 2'd2;

	logic [1:0]  state_q;
	logic [IB-1:0] pos_q;
	logic [W-1:0] acc_q [N];
	tcp_pkg::voxel_t vox_q;
	logic        out_valid_q;
	tcp_pkg::out_item_t out_q;

	// Products registered one stage ahead of the adds.
	logic [PB-1:0] pab_s1, paa_s1, pbb_s1;
	logic [W-1:0] addv [N];
	logic [N-1:0] en;
	logic         out_free;
	logic         coloc;
	logic         emit;

	assign out_free = !out_valid_q || !out_stall;
	assign v_ready = state_q == StIdle;
	assign coloc = vox_q.in1 && vox_q.in2;
	assign emit = (state_q == StMap || state_q == StDrain) && out_free;

	always_comb begin
		for (int i = 0; i < N; i++) begin
			addv[i] = W'(1);
		end
		addv[0] = W'(vox_q.a);
		addv[1] = W'(vox_q.b);
		addv[5] = W'(vox_q.a);
		addv[6] = W'(vox_q.b);
		addv[9] = W'(vox_q.a);
		addv[10] = W'(vox_q.b);
		addv[11] = W'(vox_q.a);
		addv[12] = W'(vox_q.b);
		addv[14] = W'(vox_q.a);
		addv[15] = W'(vox_q.b);
		addv[16] = W'(pab_s1);
		addv[17] = W'(paa_s1);
		addv[18] = W'(pbb_s1);
		en = '0;
		en[0] = 1'b1;
		en[1] = 1'b1;
		en[2] = 1'b1;
		en[3] = vox_q.a != '0;
		en[6] = vox_q.a != '0;
		en[4] = vox_q.b != '0;
		en[5] = vox_q.b != '0;
		en[7] = vox_q.in1;
		en[9] = vox_q.in1;
		en[12] = vox_q.in1;
		en[8] = vox_q.in2;
		en[10] = vox_q.in2;
		en[11] = vox_q.in2;
		for (int i = 13; i < N; i++) begin
			en[i] = coloc;
		end
	end

	always_ff @(posedge clk) begin
		if (v_valid && v_ready) begin
			vox_q <= v_data;
			pab_s1 <= PB'(v_data.a) * PB'(v_data.b);
			paa_s1 <= PB'(v_data.a) * PB'(v_data.a);
			pbb_s1 <= PB'(v_data.b) * PB'(v_data.b);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			pos_q <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < N; i++) begin
				acc_q[i] <= '0;
			end
		end else begin
			// drop the taken result unless a new one replaces it
			if (out_valid_q && !out_stall && !emit) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				StIdle: begin
					if (v_valid) begin
						state_q <= StMap;
					end
				end
				StMap: begin
					if (out_free) begin
						for (int i = 0; i < N; i++) begin
							if (en[i]) begin
								logic [W-1:0] cap;
								cap = tcp_pkg::IsCountStat[i] ? CountMax : SumMax;
								if (addv[i] >= cap || acc_q[i] >= cap - addv[i]) begin
									acc_q[i] <= cap;
								end else begin
									acc_q[i] <= acc_q[i] + addv[i];
								end
							end
						end
						out_valid_q <= 1'b1;
						out_q.kind <= tcp_pkg::KindMap;
						out_q.map_value <= coloc ? vox_q.map : '0;
						out_q.is_coloc <= coloc;
						out_q.stat_index <= '0;
						out_q.stat_value <= '0;
						out_q.end_of_run <= !vox_q.last;
						pos_q <= '0;
						state_q <= vox_q.last ? StDrain : StIdle;
					end
				end
				StDrain: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_q.kind <= tcp_pkg::KindStat;
						out_q.map_value <= '0;
						out_q.is_coloc <= 1'b0;
						out_q.stat_index <= pos_q;
						out_q.stat_value <= acc_q[pos_q];
						out_q.end_of_run <= pos_q == IB'(N - 1);
						acc_q[pos_q] <= '0;
						if (pos_q == IB'(N - 1)) begin
							pos_q <= '0;
							state_q <= StIdle;
						end else begin
							pos_q <= pos_q + 1'b1;
						end
					end
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;
endmodule

FILE: rtl/thresholded_colocalization_pass.sv
// ---------------------------------------------------------------------------
// thresholded_colocalization_pass
// Two-channel colocalization map with streaming Manders/Pearson statistics.
// ---------------------------------------------------------------------------
// A voxel passes the front, queue, back voxel and output registers; for a
// geometric-mean map the front's root steps come first, stalling input.
// The back takes a new voxel only after emitting the previous map result.
// A last voxel adds 19 drain results, one per cycle unless the output stalls.
// Reset clears accumulators and control; config registers take reset values.
module thresholded_colocalization_pass #(
	parameter int SAMPLE_BITS = tcp_pkg::SampleBitsDef,
	parameter int VOXEL_COUNT_BITS = tcp_pkg::VoxelCountBitsDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  tcp_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output tcp_pkg::out_item_t  out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [tcp_pkg::CfgIdxBits-1:0] cfg_index,
	input  logic [tcp_pkg::MapBits-1:0]    cfg_data
);
	tcp_pkg::cfg_t   cfg_q;
	logic            fv, fr, bv, br;
	tcp_pkg::voxel_t fd, bd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ch1_lower <= '0;
			cfg_q.ch2_lower <= '0;
			cfg_q.ch1_upper <= '1;
			cfg_q.ch2_upper <= '1;
			cfg_q.fixed_map_value <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				tcp_pkg::RegCh1Lower: cfg_q.ch1_lower <= cfg_data;
				tcp_pkg::RegCh2Lower: cfg_q.ch2_lower <= cfg_data;
				tcp_pkg::RegCh1Upper: cfg_q.ch1_upper <= cfg_data;
				tcp_pkg::RegCh2Upper: cfg_q.ch2_upper <= cfg_data;
				tcp_pkg::RegFixedMap: cfg_q.fixed_map_value <= cfg_data;
				default: ;
			endcase
		end
	end

	tcp_front #(.SampleBits(SAMPLE_BITS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.in_a(in_data.ch1_sample), .in_b(in_data.ch2_sample),
		.in_last(in_data.last_voxel), .cfg(cfg_q),
		.v_valid(fv), .v_ready(fr), .v_data(fd)
	);

	tcp_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(fv), .wr_ready(fr), .wr_data(fd),
		.rd_valid(bv), .rd_ready(br), .rd_data(bd)
	);

	tcp_back #(.SampleBits(SAMPLE_BITS), .VoxelCountBits(VOXEL_COUNT_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.v_valid(bv), .v_ready(br), .v_data(bd),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);
endmodule
